// ===== design/gbr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the 5x5 RGB Gaussian blur.
// No dependencies; every other file refers to this package by scoped names.
package gbr_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Window: [row][col], row 4 / col 4 hold the newest pixel.
    typedef rgb_t [4:0][4:0] win_t;
    typedef logic [4:0][4:0][7:0] chan_win_t;

    // Line store word: entry k holds the pixel (k+1) rows above.
    typedef rgb_t [3:0] lb_word_t;

    // Weights by group: center, d1, d2, d4, d5, d8.
    typedef logic [5:0][15:0] weight_set_t;

    typedef struct packed {
        logic [4:0] row;
        logic [4:0] col;
    } tap_mask_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_C     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_D1    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_D2    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_D4    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_D5    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_D8    = 3'd7;

    localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [15:0] FRAME_HEIGHT_RST = 16'd480;
    localparam weight_set_t WEIGHT_RST = {16'd1523, 16'd2217, 16'd2512,
                                          16'd3225, 16'd3655, 16'd4140};

    // Weight group of each tap by squared distance from the center.
    localparam logic [2:0] TAP_GROUP [5][5] = '{
        '{3'd5, 3'd4, 3'd3, 3'd4, 3'd5},
        '{3'd4, 3'd2, 3'd1, 3'd2, 3'd4},
        '{3'd3, 3'd1, 3'd0, 3'd1, 3'd3},
        '{3'd4, 3'd2, 3'd1, 3'd2, 3'd4},
        '{3'd5, 3'd4, 3'd3, 3'd4, 3'd5}
    };

endpackage

// ===== design/gbr_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: pixel in, pixel out, register write.
// Depends on gbr_pkg for configuration port widths.
interface gbr_pix_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;

    modport source (output valid, func, in_red, in_green, in_blue, input ready);
    modport sink (input valid, func, in_red, in_green, in_blue, output ready);
endinterface

interface gbr_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_of_frame;

    modport source (output valid, out_red, out_green, out_blue, last_of_frame, input ready);
    modport sink (input valid, out_red, out_green, out_blue, last_of_frame, output ready);
endinterface

interface gbr_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [gbr_pkg::CFG_INDEX_W-1:0]    index;
    logic [gbr_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== design/gbr_line_buf.sv =====
`timescale 1ns / 1ps
// Four-row line store (one wide word per column) and the 5x5 window registers.
// Depends on gbr_pkg.
module gbr_line_buf #(
    parameter int DEPTH = 2048
) (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  gbr_pkg::rgb_t              pix,
    output gbr_pkg::win_t              win
);

    gbr_pkg::lb_word_t mem [DEPTH];
    gbr_pkg::lb_word_t rd_reg;
    gbr_pkg::lb_word_t wdata;
    gbr_pkg::win_t     win_reg;

    // age the column by one row, newest pixel on top
    assign wdata = {rd_reg[2], rd_reg[1], rd_reg[0], pix};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wdata;
        end
        if (rd_en)
        begin
            // forward the column being written in the same cycle
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_reg <= wdata;
            end
            else
            begin
                rd_reg <= mem[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int r = 0; r < 5; r++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    win_reg[r][j] <= win_reg[r][j+1];
                end
            end
            win_reg[4][4] <= pix;
            win_reg[3][4] <= rd_reg[0];
            win_reg[2][4] <= rd_reg[1];
            win_reg[1][4] <= rd_reg[2];
            win_reg[0][4] <= rd_reg[3];
        end
    end

    assign win = win_reg;

endmodule

// ===== design/gbr_lane.sv =====
`timescale 1ns / 1ps
// One color channel lane: masked tap sums per weight group, six products,
// total with rounding and saturation. Depends on gbr_pkg.
module gbr_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   adv,
    input  gbr_pkg::chan_win_t     pix,
    input  gbr_pkg::tap_mask_t     mask,
    input  gbr_pkg::weight_set_t   weights,
    output logic [7:0]             result
);

    localparam int GSW = 11;
    localparam int PW  = GSW + 16;
    localparam int AW  = PW + 3;

    logic [5:0][GSW-1:0] gsum_reg, gsum_next;
    logic [5:0][PW-1:0]  prod_reg, prod_next;
    logic [7:0]          result_reg, result_next;
    logic [AW-1:0]       acc;
    logic [AW:0]         rounded;
    logic [AW:0]         shifted;

    always_comb
    begin
        gsum_next = '0;
        for (int r = 0; r < 5; r++)
        begin
            for (int j = 0; j < 5; j++)
            begin
                if (mask.row[r] && mask.col[j])
                begin
                    gsum_next[gbr_pkg::TAP_GROUP[r][j]] =
                        gsum_next[gbr_pkg::TAP_GROUP[r][j]] + GSW'(pix[r][j]);
                end
            end
        end
    end

    always_comb
    begin
        for (int g = 0; g < 6; g++)
        begin
            prod_next[g] = PW'(gsum_reg[g]) * PW'(weights[g]);
        end
    end

    always_comb
    begin
        acc = '0;
        for (int g = 0; g < 6; g++)
        begin
            acc = acc + AW'(prod_reg[g]);
        end
        rounded = (AW+1)'(acc) + ((AW+1)'(1) << (FRAC_BITS - 1));
        shifted = rounded >> FRAC_BITS;
        result_next = (shifted > (AW+1)'(255)) ? 8'hFF : shifted[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gsum_reg   <= gsum_next;
            prod_reg   <= prod_next;
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== design/gaussian_blur_5x5_rgb.sv =====
`timescale 1ns / 1ps
// 5x5 Gaussian blur over a raster RGB stream. Throughput one pixel per cycle while
// the output is not stalled, set by one line store read and one write per pixel. A result
// moves through the s1, m2, m3, m4 and output registers once the request that completes its window is taken.
// Reset: position counters clear, registers take their defaults; the line
// store is not cleared (out-of-frame taps are masked).
// Depends on gbr_pkg, gbr_stream_if, gbr_line_buf, gbr_lane.
module gaussian_blur_5x5_rgb #(
    parameter int MAX_WIDTH        = 2048,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    gbr_pix_in_if.sink      pix_in,
    gbr_pix_out_if.source   pix_out,
    gbr_cfg_if.sink         cfg
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int LW = $clog2(2 * MAX_WIDTH + 3);

    // registers
    logic [11:0]                frame_width_reg;
    logic [15:0]                frame_height_reg;
    gbr_pkg::weight_set_t       weights_reg;

    // position state
    logic [CW-1:0]  in_col_reg, in_col_next;
    logic [15:0]    in_row_reg, in_row_next;
    logic           in_done_reg, in_done_next;
    logic [LW-1:0]  lead_reg, lead_next;
    logic [CW-1:0]  out_col_reg, out_col_next;
    logic [15:0]    out_row_reg, out_row_next;

    // pipeline
    logic                   s1_valid_reg, s1_prod_reg, s1_last_reg;
    gbr_pkg::rgb_t          s1_pix_reg;
    logic [CW-1:0]          s1_col_reg;
    gbr_pkg::tap_mask_t     s1_mask_reg, m2_mask_reg, tap_mask;
    logic                   m2_valid_reg, m2_last_reg;
    logic                   m3_valid_reg, m3_last_reg;
    logic                   m4_valid_reg, m4_last_reg;
    logic                   out_valid_reg, out_last_reg;

    logic [WW-1:0]  w_eff, w_last;
    logic [15:0]    h_eff, h_last;
    logic [LW-1:0]  lead_cap;
    logic           adv, acc, ignored, go, produce, last, col_wrap, cfg_restart;
    gbr_pkg::rgb_t  in_pix;
    gbr_pkg::win_t  win;
    gbr_pkg::chan_win_t win_r, win_g, win_b;
    logic [7:0]     res_r, res_g, res_b;

    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(frame_width_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(frame_width_reg);
        end
        h_eff    = (frame_height_reg == '0) ? 16'd1 : frame_height_reg;
        w_last   = w_eff - WW'(1);
        h_last   = h_eff - 16'd1;
        lead_cap = LW'({w_eff, 1'b0}) + LW'(2);
    end

    assign adv          = !out_valid_reg || pix_out.ready;
    assign pix_in.ready = adv;
    assign acc          = pix_in.valid && adv;
    assign ignored      = pix_in.func && !in_done_reg;
    assign go           = acc && !ignored;
    assign produce      = (lead_reg == lead_cap);
    assign last         = produce && (out_row_reg == h_last) && (WW'(out_col_reg) == w_last);
    assign col_wrap     = (WW'(in_col_reg) == w_last);
    assign in_pix       = in_done_reg ? '0 :
                          gbr_pkg::rgb_t'{pix_in.in_red, pix_in.in_green, pix_in.in_blue};

    // taps outside the frame contribute nothing
    always_comb
    begin
        tap_mask.col[0] = (out_col_reg >= CW'(2));
        tap_mask.col[1] = (out_col_reg >= CW'(1));
        tap_mask.col[2] = 1'b1;
        tap_mask.col[3] = ((WW+1)'(out_col_reg) + (WW+1)'(1)) < (WW+1)'(w_eff);
        tap_mask.col[4] = ((WW+1)'(out_col_reg) + (WW+1)'(2)) < (WW+1)'(w_eff);
        tap_mask.row[0] = (out_row_reg >= 16'd2);
        tap_mask.row[1] = (out_row_reg >= 16'd1);
        tap_mask.row[2] = 1'b1;
        tap_mask.row[3] = (17'(out_row_reg) + 17'd1) < 17'(h_eff);
        tap_mask.row[4] = (17'(out_row_reg) + 17'd2) < 17'(h_eff);
    end

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_done_next = in_done_reg;
        lead_next    = lead_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        cfg_restart  = cfg.valid && ((cfg.index == gbr_pkg::REG_FRAME_WIDTH) ||
                                     (cfg.index == gbr_pkg::REG_FRAME_HEIGHT));
        if (go)
        begin
            if (last)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                in_done_next = 1'b0;
                lead_next    = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else
            begin
                if (col_wrap)
                begin
                    in_col_next = '0;
                    if (!in_done_reg)
                    begin
                        if (in_row_reg == h_last)
                        begin
                            in_done_next = 1'b1;
                        end
                        else
                        begin
                            in_row_next = in_row_reg + 16'd1;
                        end
                    end
                end
                else
                begin
                    in_col_next = in_col_reg + CW'(1);
                end
                if (produce)
                begin
                    if (WW'(out_col_reg) == w_last)
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + 16'd1;
                    end
                    else
                    begin
                        out_col_next = out_col_reg + CW'(1);
                    end
                end
                else
                begin
                    lead_next = lead_reg + LW'(1);
                end
            end
        end
        if (cfg_restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            in_done_next = 1'b0;
            lead_next    = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_done_reg <= 1'b0;
            lead_reg    <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            in_done_reg <= in_done_next;
            lead_reg    <= lead_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // register file
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= gbr_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= gbr_pkg::FRAME_HEIGHT_RST;
            weights_reg      <= gbr_pkg::WEIGHT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                gbr_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg.data[11:0];
                gbr_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg.data;
                gbr_pkg::REG_WEIGHT_C:     weights_reg[0]   <= cfg.data;
                gbr_pkg::REG_WEIGHT_D1:    weights_reg[1]   <= cfg.data;
                gbr_pkg::REG_WEIGHT_D2:    weights_reg[2]   <= cfg.data;
                gbr_pkg::REG_WEIGHT_D4:    weights_reg[3]   <= cfg.data;
                gbr_pkg::REG_WEIGHT_D5:    weights_reg[4]   <= cfg.data;
                gbr_pkg::REG_WEIGHT_D8:    weights_reg[5]   <= cfg.data;
                default:                   frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            m3_valid_reg  <= 1'b0;
            m4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= go;
            m2_valid_reg  <= s1_valid_reg && s1_prod_reg;
            m3_valid_reg  <= m2_valid_reg;
            m4_valid_reg  <= m3_valid_reg;
            out_valid_reg <= m4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pix_reg   <= in_pix;
            s1_col_reg   <= in_col_reg;
            s1_prod_reg  <= produce;
            s1_last_reg  <= last;
            s1_mask_reg  <= tap_mask;
            m2_mask_reg  <= s1_mask_reg;
            m2_last_reg  <= s1_last_reg;
            m3_last_reg  <= m2_last_reg;
            m4_last_reg  <= m3_last_reg;
            out_last_reg <= m4_last_reg;
        end
    end

    gbr_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (go),
        .rd_addr (in_col_reg),
        .wr_en   (s1_valid_reg && adv),
        .wr_addr (s1_col_reg),
        .pix     (s1_pix_reg),
        .win     (win)
    );

    always_comb
    begin
        for (int r = 0; r < 5; r++)
        begin
            for (int j = 0; j < 5; j++)
            begin
                win_r[r][j] = win[r][j].red;
                win_g[r][j] = win[r][j].green;
                win_b[r][j] = win[r][j].blue;
            end
        end
    end

    gbr_lane #(.FRAC_BITS (WEIGHT_FRAC_BITS)) u_lane_r (
        .clk (clk), .adv (adv), .pix (win_r), .mask (m2_mask_reg),
        .weights (weights_reg), .result (res_r)
    );

    gbr_lane #(.FRAC_BITS (WEIGHT_FRAC_BITS)) u_lane_g (
        .clk (clk), .adv (adv), .pix (win_g), .mask (m2_mask_reg),
        .weights (weights_reg), .result (res_g)
    );

    gbr_lane #(.FRAC_BITS (WEIGHT_FRAC_BITS)) u_lane_b (
        .clk (clk), .adv (adv), .pix (win_b), .mask (m2_mask_reg),
        .weights (weights_reg), .result (res_b)
    );

    // merge lanes into the output request
    assign pix_out.valid         = out_valid_reg;
    assign pix_out.out_red       = res_r;
    assign pix_out.out_green     = res_g;
    assign pix_out.out_blue      = res_b;
    assign pix_out.last_of_frame = out_last_reg;

`ifndef NO_ASSERTIONS
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        go && in_done_reg |=> s1_pix_reg == '0)
        else $error("pixel after frame end not zeroed");

    a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
        go && last |=> (lead_reg == '0) && (in_col_reg == '0) && !in_done_reg)
        else $error("frame counters not restarted after last output");

    a_early_drain: assert property (@(posedge clk) disable iff (!rst_n)
        acc && pix_in.func && !in_done_reg |=> !s1_valid_reg)
        else $error("early drain request entered the pipeline");
`endif

endmodule

// ===== test/gbr_blur_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the 5x5 RGB blur: follows the register writes and accepted pixel
// requests, predicts each blurred pixel and compares it with the output channel.
// Depends on gbr_pkg and the channel interfaces in gbr_stream_if.
module gbr_blur_checker #(
    parameter int MAX_WIDTH = 2048,
    parameter int FRAC_BITS = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    gbr_pix_in_if   pix_in,
    gbr_pix_out_if  pix_out,
    gbr_cfg_if      cfg,
    output int      fail_count,
    output int      outstanding,
    output int      pixels_checked,
    output int      frames_closed
);

    localparam int HIST_DEPTH = 4 * MAX_WIDTH + 8;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } blurred_t;

    logic [23:0]   history [HIST_DEPTH];
    logic [15:0]   regs [8];
    int unsigned   wr_slot, in_col, in_row, out_col, out_row;
    blurred_t      blurred_q [$];

    function automatic int unsigned frame_w();
        int unsigned w;
        w = 32'(regs[gbr_pkg::REG_FRAME_WIDTH]);
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned frame_h();
        return (regs[gbr_pkg::REG_FRAME_HEIGHT] == 0) ? 1 :
               32'(regs[gbr_pkg::REG_FRAME_HEIGHT]);
    endfunction

    function automatic logic [2:0] weight_reg(int d2);
        case (d2)
            0:       return gbr_pkg::REG_WEIGHT_C;
            1:       return gbr_pkg::REG_WEIGHT_D1;
            2:       return gbr_pkg::REG_WEIGHT_D2;
            4:       return gbr_pkg::REG_WEIGHT_D4;
            5:       return gbr_pkg::REG_WEIGHT_D5;
            default: return gbr_pkg::REG_WEIGHT_D8;
        endcase
    endfunction

    function automatic logic [7:0] round_clip(longint unsigned acc);
        longint unsigned v;
        v = (acc + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic void restart();
        wr_slot = 0;
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    // Advance the model by one accepted request; queue a blurred pixel when one is due.
    function automatic void blur_step(logic drain, logic [23:0] rgb);
        int unsigned w, h, total, idx, age, slot;
        int r, c;
        longint unsigned acc_r, acc_g, acc_b, wt;
        logic [23:0] p;
        blurred_t res;
        w = frame_w();
        h = frame_h();
        total = w * h;
        idx = in_row * w + in_col;
        if (drain && idx < total) return;
        history[wr_slot] = (idx < total) ? rgb : 24'd0;
        if (idx >= 2 * w + 2) begin
            acc_r = 0;
            acc_g = 0;
            acc_b = 0;
            for (int dy = -2; dy <= 2; dy++) begin
                for (int dx = -2; dx <= 2; dx++) begin
                    r = int'(out_row) + dy;
                    c = int'(out_col) + dx;
                    if (r < 0 || c < 0 || r >= int'(h) || c >= int'(w)) continue;
                    age = idx - (r * w + c);
                    if (age >= HIST_DEPTH) continue;
                    slot = (wr_slot + HIST_DEPTH - age) % HIST_DEPTH;
                    p = history[slot];
                    wt = regs[weight_reg(dx * dx + dy * dy)];
                    acc_r += wt * p[23:16];
                    acc_g += wt * p[15:8];
                    acc_b += wt * p[7:0];
                end
            end
            res.red   = round_clip(acc_r);
            res.green = round_clip(acc_g);
            res.blue  = round_clip(acc_b);
            res.last  = (out_row * w + out_col == total - 1);
            blurred_q.push_back(res);
            if (res.last) begin
                restart();
                return;
            end
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        wr_slot = (wr_slot + 1) % HIST_DEPTH;
    endfunction

    always @(posedge clk) begin
        blurred_t want;
        if (!rst_n) begin
            regs[gbr_pkg::REG_FRAME_WIDTH]  = {4'd0, gbr_pkg::FRAME_WIDTH_RST};
            regs[gbr_pkg::REG_FRAME_HEIGHT] = gbr_pkg::FRAME_HEIGHT_RST;
            for (int i = 0; i < 6; i++) regs[i + 2] = gbr_pkg::WEIGHT_RST[i];
            restart();
            blurred_q.delete();
            fail_count     <= 0;
            pixels_checked <= 0;
            frames_closed  <= 0;
        end else begin
            if (pix_out.valid && pix_out.ready) begin
                pixels_checked <= pixels_checked + 1;
                if (blurred_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: unexpected output pixel %h %h %h last=%b", $time,
                                 pix_out.out_red, pix_out.out_green, pix_out.out_blue,
                                 pix_out.last_of_frame);
                    fail_count <= fail_count + 1;
                end else begin
                    want = blurred_q.pop_front();
                    if (want.last) frames_closed <= frames_closed + 1;
                    if (want.red !== pix_out.out_red || want.green !== pix_out.out_green
                        || want.blue !== pix_out.out_blue
                        || want.last !== pix_out.last_of_frame) begin
                        if (fail_count < 10)
                            $display("%0t: mismatch exp %h %h %h last=%b got %h %h %h last=%b",
                                     $time, want.red, want.green, want.blue, want.last,
                                     pix_out.out_red, pix_out.out_green, pix_out.out_blue,
                                     pix_out.last_of_frame);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (pix_in.valid && pix_in.ready)
                blur_step(pix_in.func, {pix_in.in_red, pix_in.in_green, pix_in.in_blue});
            if (cfg.valid && cfg.ready) begin
                if (cfg.index == gbr_pkg::REG_FRAME_WIDTH) begin
                    regs[gbr_pkg::REG_FRAME_WIDTH] = {4'd0, cfg.data[11:0]};
                    restart();
                end else begin
                    regs[cfg.index] = cfg.data;
                    if (cfg.index == gbr_pkg::REG_FRAME_HEIGHT) restart();
                end
            end
        end
        outstanding <= blurred_q.size();
    end
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Top of the blur testbench: clock, reset, register writes, pixel stimulus and verdict.
// Depends on gbr_pkg, gbr_stream_if, gbr_blur_checker and the blur RTL.
module tb;

    localparam int CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    int   fail_count, outstanding, pixels_checked, frames_closed;
    int   cycles = 0;
    int   stall_left = 0;
    int   hold_req = 0;
    int   hold_seen = 0;
    bit   calm;
    int   sent, frames_sent, early_drains;

    gbr_pix_in_if  pix_in ();
    gbr_pix_out_if pix_out ();
    gbr_cfg_if     cfg ();

    gaussian_blur_5x5_rgb DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .pix_out (pix_out),
        .cfg     (cfg)
    );

    gbr_blur_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .pix_in         (pix_in),
        .pix_out        (pix_out),
        .cfg            (cfg),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .pixels_checked (pixels_checked),
        .frames_closed  (frames_closed)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request.
    always @(negedge clk) begin
        if (hold_seen != hold_req) begin
            hold_seen     <= hold_req;
            stall_left    <= 400;
            pix_out.ready <= 1'b0;
        end else if (stall_left > 0) begin
            pix_out.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            pix_out.ready <= calm || ($urandom_range(99) >= 11);
        end
    end

    task automatic send_pixel(logic drain, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 11) begin
            pix_in.valid = 1'b0;
            @(negedge clk);
        end
        pix_in.valid    = 1'b1;
        pix_in.func     = drain;
        pix_in.in_red   = r;
        pix_in.in_green = g;
        pix_in.in_blue  = b;
        @(posedge clk);
        while (!pix_in.ready) @(posedge clk);
        sent++;
    endtask

    task automatic send_random(logic drain);
        send_pixel(drain, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Drop valid and hold until every predicted pixel has left the block.
    task automatic settle();
        @(negedge clk);
        pix_in.valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    // Hold pixel requests off and let results drain before touching a register.
    task automatic write_reg(logic [2:0] idx, logic [15:0] value);
        @(negedge clk);
        pix_in.valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data  = value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom);
            default: return 16'($urandom_range(6000));
        endcase
    endfunction

    // One frame from pixel 'first' on: pixels with the odd ignored early drain,
    // then the flush with the odd surplus pixel standing in for a drain step.
    task automatic run_frame(int w, int h, int first, int early_pct, int surplus_pct);
        for (int i = first; i < w * h; i++) begin
            if ($urandom_range(99) < early_pct) begin
                send_random(1'b1);
                early_drains++;
            end
            send_random(1'b0);
        end
        for (int i = 0; i < 2 * w + 2; i++)
            send_random($urandom_range(99) >= surplus_pct);
        frames_sent++;
    endtask

    initial begin
        int w, h, n;
        pix_in.valid = 1'b0;
        pix_in.func = 1'b0;
        pix_in.in_red = '0;
        pix_in.in_green = '0;
        pix_in.in_blue = '0;
        cfg.valid = 1'b0;
        cfg.index = gbr_pkg::REG_FRAME_WIDTH;
        cfg.data = '0;
        calm = 1'b0;
        sent = 0;
        frames_sent = 0;
        early_drains = 0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: saturating weights, 3x2 frame with extreme pixels,
        // an early drain and a surplus pixel in the flush.
        write_reg(gbr_pkg::REG_FRAME_WIDTH, 16'd3);
        write_reg(gbr_pkg::REG_FRAME_HEIGHT, 16'd2);
        write_reg(gbr_pkg::REG_WEIGHT_C, 16'hFFFF);
        write_reg(gbr_pkg::REG_WEIGHT_D1, 16'hFFFF);
        write_reg(gbr_pkg::REG_WEIGHT_D2, 16'd0);
        write_reg(gbr_pkg::REG_WEIGHT_D4, 16'h8000);
        write_reg(gbr_pkg::REG_WEIGHT_D5, 16'd1);
        write_reg(gbr_pkg::REG_WEIGHT_D8, 16'hFFFF);
        send_pixel(1'b0, 8'hFF, 8'h00, 8'hFF);
        send_pixel(1'b0, 8'h00, 8'hFF, 8'h00);
        send_pixel(1'b1, 8'h12, 8'h34, 8'h56);
        send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(1'b0, 8'h00, 8'h00, 8'h00);
        send_pixel(1'b0, 8'h80, 8'h7F, 8'h01);
        send_pixel(1'b0, 8'hAA, 8'h55, 8'hFE);
        for (int i = 0; i < 8; i++) send_pixel(i == 3 ? 1'b0 : 1'b1, 8'hFF, 8'hFF, 8'hFF);
        settle();
        // Zero geometry acts as a 1x1 frame.
        write_reg(gbr_pkg::REG_FRAME_WIDTH, 16'd0);
        write_reg(gbr_pkg::REG_FRAME_HEIGHT, 16'd0);
        send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
        for (int i = 0; i < 4; i++) send_random(1'b1);
        settle();
        // Geometry rewrite after a partial frame restarts it; the tallest height is
        // written, takes two pixels and is then replaced.
        write_reg(gbr_pkg::REG_FRAME_WIDTH, 16'd4);
        write_reg(gbr_pkg::REG_FRAME_HEIGHT, 16'hFFFF);
        send_random(1'b0);
        send_random(1'b0);
        settle();
        write_reg(gbr_pkg::REG_FRAME_HEIGHT, 16'd3);
        write_reg(gbr_pkg::REG_WEIGHT_C, 16'd4140);
        write_reg(gbr_pkg::REG_WEIGHT_D1, 16'd3655);
        write_reg(gbr_pkg::REG_WEIGHT_D2, 16'd3225);
        write_reg(gbr_pkg::REG_WEIGHT_D4, 16'd2512);
        write_reg(gbr_pkg::REG_WEIGHT_D5, 16'd2217);
        write_reg(gbr_pkg::REG_WEIGHT_D8, 16'd1523);

        // Oversized width clamps to the widest row: no output may appear early.
        write_reg(gbr_pkg::REG_FRAME_WIDTH, 16'hFFFF);
        write_reg(gbr_pkg::REG_FRAME_HEIGHT, 16'd1);
        for (int i = 0; i < 64; i++) send_random(1'b0);
        settle();

        // Long receiver hold-off while the sender keeps offering, to back up the block.
        write_reg(gbr_pkg::REG_FRAME_WIDTH, 16'd24);
        write_reg(gbr_pkg::REG_FRAME_HEIGHT, 16'd3);
        hold_req++;
        run_frame(24, 3, 0, 0, 1);
        settle();

        // Random frames, mostly small.
        while (sent < 950) begin
            calm = (sent > 300 && sent < 480);
            n = 0;
            w = ($urandom_range(15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            write_reg(gbr_pkg::REG_FRAME_WIDTH, 16'(w));
            write_reg(gbr_pkg::REG_FRAME_HEIGHT, 16'(h));
            for (int i = 0; i < 6; i++)
                if ($urandom_range(2) == 0)
                    write_reg(3'(gbr_pkg::REG_WEIGHT_C + i), pick_weight());
            if ($urandom_range(9) == 0) begin
                // Broken frame: abandon it part way and restart it by rewriting the same width.
                n = $urandom_range(1, w * h);
                for (int i = 0; i < n; i++) send_random(1'b0);
                settle();
                n = 0;
                write_reg(gbr_pkg::REG_FRAME_WIDTH, 16'(w));
            end else if ($urandom_range(9) == 0) begin
                // Weight change part way through a frame, then finish the frame.
                n = (2 * w + 3 < w * h) ? 2 * w + 3 : w * h;
                for (int i = 0; i < n; i++) send_random(1'b0);
                settle();
                write_reg(3'(gbr_pkg::REG_WEIGHT_C + $urandom_range(5)), pick_weight());
            end
            run_frame(w, h, n, 5, 10);
            if ($urandom_range(3) == 0) settle();
        end
        calm = 1'b0;
        settle();

        $display("Ran %0d frames incl. clamped width, 1x1 and mid-frame weight cases,",
                 frames_sent);
        $display("%0d ignored early drains; checked %0d output pixels, %0d frame ends.",
                 early_drains, pixels_checked, frames_closed);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
